// ----- src/sirf_pkg.sv -----
// shared types, constants and helper functions of the radix formatter
package sirf_pkg;

   localparam int NUMBER_W    = 32;
   localparam int SYMBOL_W    = 8;
   localparam int RADIX_W     = 5;
   localparam int WORD_W      = 64;
   localparam int ALPHA_W     = 2 * WORD_W;
   localparam int DIGIT_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int MAX_RADIX   = 16;
   localparam int DIGIT_DEPTH = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int ALPHA_SIZE  = 16;

   localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYM_LOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYM_HI  = 2'd2;

   // classified item handed from front to back
   typedef struct packed {
      logic                negative;
      logic [NUMBER_W-1:0] magnitude;
   } sirf_item_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic [ALPHA_W-1:0] symbols;
   } sirf_cfg_type;

   // back end status
   typedef struct packed {
      logic emitting;
      logic has_digits;
   } sirf_status_type;

   // alphabet symbol for one digit value
   function automatic logic [SYMBOL_W-1:0] symbol_at(logic [DIGIT_W-1:0] digit,
                                                    logic [ALPHA_W-1:0] symbols);
      symbol_at = symbols[{digit, 3'b000} +: SYMBOL_W];
   endfunction

   // radix in range, no sign characters and no repeated symbols
   function automatic logic alphabet_ok(logic [RADIX_W-1:0] radix,
                                        logic [ALPHA_W-1:0] symbols);
      logic                ok;
      logic [SYMBOL_W-1:0] sa;
      ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));
      for (int a = 0; a < ALPHA_SIZE; a++) begin
         sa = symbols[a*SYMBOL_W +: SYMBOL_W];
         if (RADIX_W'(a) < radix) begin
            if (sa == CHAR_PLUS || sa == CHAR_MINUS) begin
               ok = 1'b0;
            end
            for (int b = a + 1; b < ALPHA_SIZE; b++) begin
               if (RADIX_W'(b) < radix && symbols[b*SYMBOL_W +: SYMBOL_W] == sa) begin
                  ok = 1'b0;
               end
            end
         end
      end
      alphabet_ok = ok;
   endfunction

   // index of the highest nonzero byte, zero for a zero word
   function automatic logic [1:0] top_byte(logic [NUMBER_W-1:0] value);
      if (value[31:24] != 8'd0) begin
         top_byte = 2'd3;
      end else if (value[23:16] != 8'd0) begin
         top_byte = 2'd2;
      end else if (value[15:8] != 8'd0) begin
         top_byte = 2'd1;
      end else begin
         top_byte = 2'd0;
      end
   endfunction

endpackage

// ----- src/signed_integer_radix_formatter.sv -----
// top level of the signed integer radix formatter
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_number (signed 32)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_symbol (8), rsp_last
//   csr     | in        | csr_write           | csr_index (2), csr_data (64)
//
// an item leaves the queue into the divider, which for each digit steps through the
// significant bytes of the current quotient (the byte-wise divider loop); the symbols
// then go one by one into the output register, which holds a shown symbol while
// rsp_stall is high.
// reset is synchronous and clears the queue, sequencer and configuration.
// the queue keeps accepting items while not full, also while the back end divides or waits on rsp_stall.
module signed_integer_radix_formatter #(
   parameter int DIGIT_DEPTH = sirf_pkg::DIGIT_DEPTH,
   parameter int QUEUE_DEPTH = sirf_pkg::QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sirf_pkg::NUMBER_W-1:0]   req_number,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sirf_pkg::SYMBOL_W-1:0]          rsp_symbol,
   output logic                                   rsp_last,
   input  logic                                   csr_write,
   input  logic [sirf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sirf_pkg::WORD_W-1:0]            csr_data
);
   import sirf_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [WORD_W-1:0]  sym_low_ff;
   logic [WORD_W-1:0]  sym_high_ff;
   sirf_cfg_type       cfg;
   sirf_item_type      push_item, pop_item;
   sirf_status_type    status;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= '0;
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIX:   radix_ff    <= csr_data[RADIX_W-1:0];
            CSR_SYM_LOW: sym_low_ff  <= csr_data;
            CSR_SYM_HI:  sym_high_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.radix   = radix_ff;
   assign cfg.symbols = {sym_high_ff, sym_low_ff};

   sirf_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   sirf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sirf_back #(
      .DIGIT_DEPTH (DIGIT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .status     (status)
   );

   // emitting always has digits left to send
   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      status.emitting |-> status.has_digits)
      else $error("back end emitting with an empty digit stack");

   // a non-final symbol on the output means the rest of its item is still pending
   a_more_after_nonlast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> status.emitting)
      else $error("non-final symbol shown but back end left emission");

   // a sign symbol is never the final symbol of an item
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_symbol != CHAR_MINUS || $past(status.has_digits))
      else $error("minus sign emitted as final symbol");

endmodule

// ----- src/sirf_front.sv -----
// front end: takes input items, splits sign and magnitude
module sirf_front (
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [sirf_pkg::NUMBER_W-1:0]        req_number,
   output logic                                        push_valid,
   input  logic                                        push_ready,
   output sirf_pkg::sirf_item_type                     push_item
);
   import sirf_pkg::*;

   logic [NUMBER_W-1:0] raw;

   // stall while the queue is full
   assign req_stall  = !push_ready;
   assign push_valid = req_valid;

   // sign and unsigned magnitude, the most negative value gives 2^31
   assign raw                = $unsigned(req_number);
   assign push_item.negative = raw[NUMBER_W-1];
   assign push_item.magnitude = raw[NUMBER_W-1] ? (NUMBER_W'(0) - raw) : raw;

endmodule

// ----- src/sirf_queue.sv -----
// short fifo between front and back end
module sirf_queue #(
   parameter int DEPTH = sirf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  sirf_pkg::sirf_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output sirf_pkg::sirf_item_type pop_item
);
   import sirf_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   sirf_item_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff,   fill_in;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != CW'(DEPTH));
   assign pop_valid  = (fill_ff != CW'(0));
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/sirf_back.sv -----
// back end: byte-wise divider, digit stack and symbol output register
module sirf_back #(
   parameter int DIGIT_DEPTH = sirf_pkg::DIGIT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sirf_pkg::sirf_cfg_type            cfg,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  sirf_pkg::sirf_item_type           pop_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sirf_pkg::SYMBOL_W-1:0]     rsp_symbol,
   output logic                              rsp_last,
   output sirf_pkg::sirf_status_type         status
);
   import sirf_pkg::*;

   localparam int AW = $clog2(DIGIT_DEPTH);
   localparam int CW = $clog2(DIGIT_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                sign_ff, sign_in;
   logic [NUMBER_W-1:0] dvd_ff, dvd_in;
   logic [NUMBER_W-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [1:0]          byte_ff, byte_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [DIGIT_W-1:0]  stack_ff [DIGIT_DEPTH];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [7:0]          dvd_byte;
   logic [7:0]          q_byte;
   logic [DIGIT_W-1:0]  rem_new;
   logic [NUMBER_W-1:0] quot_new;
   logic                digit_done;
   logic                push_digit;
   logic                out_free;
   logic [AW-1:0]       rd_idx;
   logic                pop_take;

   // one dividend byte per cycle, eight restoring steps
   always_comb begin
      logic [DIGIT_W:0]   t;
      logic [DIGIT_W-1:0] r;
      dvd_byte = 8'(dvd_ff >> {byte_ff, 3'b000});
      r        = rem_ff;
      q_byte   = '0;
      for (int i = 7; i >= 0; i--) begin
         t = {r, dvd_byte[i]};
         if (t >= cfg.radix) begin
            t         = t - cfg.radix;
            q_byte[i] = 1'b1;
         end
         r = t[DIGIT_W-1:0];
      end
      rem_new  = r;
      quot_new = quot_ff | (NUMBER_W'(q_byte) << {byte_ff, 3'b000});
   end

   assign pop_ready  = (state_ff == ST_IDLE);
   assign pop_take   = pop_valid && pop_ready;
   assign digit_done = (state_ff == ST_DIV) && (byte_ff == 2'd0);
   assign push_digit = digit_done && (count_ff < CW'(DIGIT_DEPTH));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rd_idx     = AW'(count_ff - CW'(1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sign_in       = sign_ff;
      dvd_in        = dvd_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      byte_in       = byte_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_take) begin
               count_in = '0;
               if (alphabet_ok(cfg.radix, cfg.symbols)) begin
                  sign_in  = pop_item.negative;
                  dvd_in   = pop_item.magnitude;
                  quot_in  = '0;
                  rem_in   = '0;
                  byte_in  = top_byte(pop_item.magnitude);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (byte_ff == 2'd0) begin
               if (push_digit) begin
                  count_in = count_ff + CW'(1);
               end
               if (quot_new == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  dvd_in  = quot_new;
                  quot_in = '0;
                  rem_in  = '0;
                  byte_in = top_byte(quot_new);
               end
            end else begin
               quot_in = quot_new;
               rem_in  = rem_new;
               byte_in = byte_ff - 2'd1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_symbol_in = CHAR_MINUS;
                  rsp_last_in   = 1'b0;
                  sign_in       = 1'b0;
               end else begin
                  rsp_symbol_in = symbol_at(stack_ff[rd_idx], cfg.symbols);
                  rsp_last_in   = (count_ff == CW'(1));
                  count_in      = count_ff - CW'(1);
                  if (count_ff == CW'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dvd_ff        <= dvd_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      byte_ff       <= byte_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // digit stack, least significant digit first
   always_ff @(posedge clock) begin
      if (push_digit) begin
         stack_ff[AW'(count_ff)] <= rem_new;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_symbol        = rsp_symbol_ff;
   assign rsp_last          = rsp_last_ff;
   assign status.emitting   = (state_ff == ST_EMIT);
   assign status.has_digits = (count_ff != CW'(0));

endmodule
